// ===== hw/rtl/gbn_pkg.sv =====
// gbn_pkg: beat types, command codes and event codes of the go-back-n sender
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int DATA_W = 64;
    localparam int SEQ_OUT_W = 8;

    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [1:0] EV_REFUSED = 2'd0;
    localparam logic [1:0] EV_XMIT    = 2'd1;
    localparam logic [1:0] EV_STOP    = 2'd2;
    localparam logic [1:0] EV_START   = 2'd3;

    typedef struct packed {
        logic [1:0]           command;
        logic [DATA_W-1:0]    payload;
        logic [SEQ_OUT_W-1:0] ack_num;
        logic                 ack_checksum_ok;
        logic [SEQ_OUT_W-1:0] timer_seq;
    } gbn_in_t;

    typedef struct packed {
        logic [1:0]           event_kind;
        logic [SEQ_OUT_W-1:0] seq_num;
        logic [DATA_W-1:0]    data_out;
        logic                 window_full;
        logic                 last;
    } gbn_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbn_store.sv =====
// gbn_store: packet buffer, one write port and one registered read port
// no dependencies; instantiated by go_back_n_sender
`timescale 1ns / 1ps
`default_nettype none

module gbn_store #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int WIDTH  = 64
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/go_back_n_sender.sv =====
// go_back_n_sender: go-back-n sender window with packet buffer and replay
// depends on gbn_pkg and gbn_store
//
// usage: one command beat on s_* (send, ack, timeout) gives zero to
// WINDOW+2 result beats on m_* (window capped at SEQ_SPACE-1), the final one marked by last.
// a send stores its payload in the slot of the next sequence number and
// transmits it, starting the timer if the window was empty; a send into a
// full window gives one refused beat. a valid ack inside the outstanding
// range moves the base and stops/restarts the timer. a timeout gives stop and
// start beats for the tag, then replays every outstanding packet, oldest first.
// timing: a command is taken only while the sequencer is idle; each fixed
// result beat is loaded straight into the output register, each replayed
// packet is first read from the buffer (ST_READ), then loaded into the
// output register (ST_SEND); an ignored command leaves the sequencer idle. the
// command is registered, then ST_FIRST loads the first beat once the output register is free.
// the output register lets the next command be taken while the final result
// still waits; m_ready low simply holds the sequencer on the current beat.
// reset clears base, next sequence number, full flag and the output valid;
// the packet buffer is not cleared, only written slots are ever replayed.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender
    import gbn_pkg::*;
#(
    parameter int SEQ_SPACE    = 8,
    parameter int WINDOW       = 4,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire gbn_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output gbn_out_t     m_data
);

    localparam int SW = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
    localparam int EFF_WIN = (WINDOW < SEQ_SPACE) ? WINDOW : (SEQ_SPACE - 1);
    localparam logic [SW-1:0] SEQ_MAX = SW'(SEQ_SPACE - 1);
    localparam logic [SW:0] SPACE = (SW + 1)'(SEQ_SPACE);
    localparam logic [SW-1:0] EFF = SW'(EFF_WIN);
    localparam logic [SEQ_OUT_W:0] ACK_LIM = (SEQ_OUT_W + 1)'(SEQ_SPACE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_READ,
        ST_SEND
    } state_t;

    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] v);
        seq_inc = (v == SEQ_MAX) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [SW-1:0] seq_sub(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b);
        logic [SW:0] t;
        t = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + SPACE - {1'b0, b});
        seq_sub = t[SW-1:0];
    endfunction

    state_t                state_reg;
    logic [SW-1:0]         base_reg;
    logic [SW-1:0]         next_seq_reg;
    logic                  full_reg;
    logic                  m_valid_reg;
    gbn_out_t              m_data_reg;

    logic [1:0]            a_kind_reg;
    logic [SEQ_OUT_W-1:0]  a_seq_reg;
    logic [DATA_W-1:0]     a_data_reg;
    logic                  has_b_reg;
    logic [SEQ_OUT_W-1:0]  b_seq_reg;
    logic [SW-1:0]         cnt_reg;
    logic [SW-1:0]         rp_seq_reg;
    logic                  full_out_reg;

    logic                  in_beat;
    logic                  out_free;
    logic                  out_load;
    logic [SW-1:0]         outst;
    logic [SW-1:0]         send_next;
    logic [SW-1:0]         ack_s;
    logic [SW-1:0]         ack_base;
    logic                  ack_hit;

    logic                  plan_go;
    logic [1:0]            a_kind_next;
    logic [SEQ_OUT_W-1:0]  a_seq_next;
    logic [DATA_W-1:0]     a_data_next;
    logic                  has_b_next;
    logic [SEQ_OUT_W-1:0]  b_seq_next;
    logic [SW-1:0]         cnt_next;
    logic                  full_next;
    logic [SW-1:0]         base_next;
    logic [SW-1:0]         next_seq_next;

    logic                  wr_en;
    logic                  rd_en;
    logic [PAYLOAD_BITS-1:0] rd_data;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = out_free && ((state_reg == ST_FIRST) || (state_reg == ST_SECOND)
                                   || (state_reg == ST_SEND));
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign outst     = seq_sub(next_seq_reg, base_reg);
    assign send_next = seq_inc(next_seq_reg);
    assign ack_s     = s_data.ack_num[SW-1:0];
    assign ack_base  = seq_inc(ack_s);
    assign ack_hit   = s_data.ack_checksum_ok
                    && ({1'b0, s_data.ack_num} < ACK_LIM)
                    && (seq_sub(ack_s, base_reg) < outst);

    always_comb begin
        plan_go       = 1'b0;
        a_kind_next   = EV_REFUSED;
        a_seq_next    = SEQ_OUT_W'(next_seq_reg);
        a_data_next   = '0;
        has_b_next    = 1'b0;
        b_seq_next    = '0;
        cnt_next      = '0;
        full_next     = full_reg;
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        case (s_data.command)
            CMD_SEND: begin
                plan_go = 1'b1;
                if (!full_reg) begin
                    a_kind_next   = EV_XMIT;
                    a_data_next   = DATA_W'(s_data.payload[PAYLOAD_BITS-1:0]);
                    has_b_next    = (base_reg == next_seq_reg);
                    b_seq_next    = SEQ_OUT_W'(next_seq_reg);
                    next_seq_next = send_next;
                    full_next     = (seq_sub(send_next, base_reg) >= EFF);
                end
            end
            CMD_ACK: begin
                if (ack_hit) begin
                    plan_go     = 1'b1;
                    a_kind_next = EV_STOP;
                    a_seq_next  = SEQ_OUT_W'(base_reg);
                    has_b_next  = (ack_base != next_seq_reg);
                    b_seq_next  = SEQ_OUT_W'(ack_base);
                    base_next   = ack_base;
                    full_next   = 1'b0;
                end
            end
            CMD_TIMEOUT: begin
                plan_go     = 1'b1;
                a_kind_next = EV_STOP;
                a_seq_next  = s_data.timer_seq;
                has_b_next  = 1'b1;
                b_seq_next  = s_data.timer_seq;
                cnt_next    = outst;
            end
            default: begin
                plan_go = 1'b0;
            end
        endcase
    end

    assign wr_en = in_beat && (s_data.command == CMD_SEND) && !full_reg;
    assign rd_en = (state_reg == ST_READ);

    gbn_store #(
        .DEPTH  (SEQ_SPACE),
        .ADDR_W (SW),
        .WIDTH  (PAYLOAD_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (next_seq_reg),
        .wr_data (s_data.payload[PAYLOAD_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rp_seq_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            base_reg     <= '0;
            next_seq_reg <= '0;
            full_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat && plan_go) begin
                        a_kind_reg   <= a_kind_next;
                        a_seq_reg    <= a_seq_next;
                        a_data_reg   <= a_data_next;
                        has_b_reg    <= has_b_next;
                        b_seq_reg    <= b_seq_next;
                        cnt_reg      <= cnt_next;
                        rp_seq_reg   <= base_reg;
                        full_out_reg <= full_next;
                        full_reg     <= full_next;
                        base_reg     <= base_next;
                        next_seq_reg <= next_seq_next;
                        state_reg    <= ST_FIRST;
                    end
                end
                ST_FIRST: begin
                    if (out_free) begin
                        m_data_reg.event_kind  <= a_kind_reg;
                        m_data_reg.seq_num     <= a_seq_reg;
                        m_data_reg.data_out    <= a_data_reg;
                        m_data_reg.window_full <= full_out_reg;
                        m_data_reg.last        <= !has_b_reg && (cnt_reg == '0);
                        if (has_b_reg) begin
                            state_reg <= ST_SECOND;
                        end else if (cnt_reg != '0) begin
                            state_reg <= ST_READ;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SECOND: begin
                    if (out_free) begin
                        m_data_reg.event_kind  <= EV_START;
                        m_data_reg.seq_num     <= b_seq_reg;
                        m_data_reg.data_out    <= '0;
                        m_data_reg.window_full <= full_out_reg;
                        m_data_reg.last        <= (cnt_reg == '0);
                        state_reg <= (cnt_reg != '0) ? ST_READ : ST_IDLE;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SEND;
                end
                ST_SEND: begin
                    if (out_free) begin
                        m_data_reg.event_kind  <= EV_XMIT;
                        m_data_reg.seq_num     <= SEQ_OUT_W'(rp_seq_reg);
                        m_data_reg.data_out    <= DATA_W'(rd_data);
                        m_data_reg.window_full <= full_out_reg;
                        m_data_reg.last        <= (cnt_reg == SW'(1));
                        rp_seq_reg <= seq_inc(rp_seq_reg);
                        cnt_reg    <= cnt_reg - 1'b1;
                        state_reg  <= (cnt_reg == SW'(1)) ? ST_IDLE : ST_READ;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
